// ----- rtl/preview_tile_table_macros.svh -----
// ----------------------------------------------------------------------------
// Preview tile table assertion macros
// Shared concurrent assertion forms used by the tile table top level.
// ----------------------------------------------------------------------------
`ifndef PREVIEW_TILE_TABLE_MACROS_SVH
`define PREVIEW_TILE_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Preview tile table package
// Types, codes and constants shared by the tile table modules.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int unsigned DefaultDepth = 32;
	localparam logic [16:0] TpaReset = 17'd16;
	localparam logic [1:0]  TpaAddr = 2'd0;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_MARK    = 2'd2,
		OP_RETIRE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_STALE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] material_key;
		logic [31:0] revision;
		logic [63:0] fingerprint;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  atlas_number;
		logic [4:0]  tile_number;
		logic [31:0] entry_revision_out;
		logic [63:0] entry_fingerprint_out;
		logic [63:0] baked_fingerprint_out;
		logic        is_ready;
		logic [5:0]  active_total;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] revision;
		logic [63:0] fingerprint;
		logic [63:0] baked;
		logic [4:0]  page;
		logic [4:0]  tile;
		logic        ready;
		logic        active;
	} entry_t;

	// Control travelling along the chain with the rotating entries.
	typedef struct packed {
		logic        hit;
		logic        write;
		logic        retire;
		entry_t      wdata;
	} cell_ctl_t;

endpackage

// ----- rtl/ptt_cell.sv -----
// ----------------------------------------------------------------------------
// Preview tile table cell
// Holds one entry and passes it to the next cell every shift cycle.
// ----------------------------------------------------------------------------
module ptt_cell
	import ptt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t din,
	output entry_t dout
);

	entry_t data_q;
	logic   active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (shift) begin
			active_q <= din.active;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	always_comb begin
		dout        = data_q;
		dout.active = active_q;
	end

endmodule

// ----- rtl/preview_tile_table.sv -----
// ----------------------------------------------------------------------------
// Preview tile table
// Keyed table of preview tiles held in a rotating chain of entry cells.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req (req_t)
// rsp      out        rsp_valid/rsp_stall  rsp (rsp_t)
// cfg      in         APB write/read       tiles_per_atlas at address 0
//
// A request is captured in S_IDLE; in S_SCAN the cell chain then makes one
// full rotation, during which every entry passes the head cell once; S_DONE
// registers the result. Reset clears all valid flags and counters at once.
// A request is held off while a previous result still waits on rsp_stall.
// ----------------------------------------------------------------------------
`include "preview_tile_table_macros.svh"

module preview_tile_table
	import ptt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DefaultDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t       state_q;
	req_t         req_q;
	logic [16:0]  tpa_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] used_q;
	logic [5:0]   active_q;
	logic [4:0]   page_q;
	logic [16:0]  tile_q;
	logic         found_q;
	logic [1:0]   st_q;
	entry_t       hit_q;
	logic         rsp_valid_q;
	rsp_t         rsp_q;

	entry_t chain [TABLE_DEPTH];
	entry_t head_in;
	entry_t head;
	logic   shift;
	logic   match;
	logic [16:0] tile_inc;

	assign pready    = 1'b1;
	assign prdata    = {15'd0, tpa_q};
	assign req_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign shift = (state_q == S_SCAN);
	assign head  = chain[TABLE_DEPTH-1];
	// Lowest slot in rotation order is the first to reach the head.
	assign match = head.active && (head.key == req_q.material_key) && !found_q;
	assign tile_inc = tile_q + 17'd1;

	// Modify the entry as it passes the head.
	always_comb begin
		head_in = head;
		if (match) begin
			unique case (op_t'(req_q.op))
				OP_RESERVE: begin
					if (head.revision != req_q.revision ||
						head.fingerprint != req_q.fingerprint) begin
						head_in.revision    = req_q.revision;
						head_in.fingerprint = req_q.fingerprint;
						head_in.ready       = 1'b0;
					end
				end
				OP_MARK: begin
					if (head.fingerprint == req_q.fingerprint) begin
						head_in.baked = req_q.fingerprint;
						head_in.ready = 1'b1;
					end
				end
				OP_RETIRE: head_in.active = 1'b0;
				OP_RESOLVE: head_in = head;
				default: head_in = head;
			endcase
		end else if (!found_q && op_t'(req_q.op) == OP_RESERVE &&
			cnt_q == CW'(TABLE_DEPTH - 1) && used_q < CW'(TABLE_DEPTH)) begin
			// Last rotation slot index equals used count position after wrap.
			head_in = head;
		end
	end

	// Allocation: during scan, the slot at position used_q passes the head at
	// step used_q; it is never written, so it is claimed if no hit occurs by end.
	logic alloc_here;
	assign alloc_here = (op_t'(req_q.op) == OP_RESERVE) && !found_q && !match &&
		(cnt_q == used_q) && (used_q < CW'(TABLE_DEPTH));

	entry_t new_e;
	always_comb begin
		new_e.key         = req_q.material_key;
		new_e.revision    = req_q.revision;
		new_e.fingerprint = req_q.fingerprint;
		new_e.baked       = 64'd0;
		new_e.page        = page_q;
		new_e.tile        = tile_q[4:0];
		new_e.ready       = 1'b0;
		new_e.active      = 1'b1;
	end

	// An allocation is deferred: a later hit is impossible since slots at or
	// above used_q are never active, so the slot can be written when reached.
	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			entry_t cin;
			if (g == 0) begin : g_first
				assign cin = alloc_here ? new_e : head_in;
			end else begin : g_rest
				assign cin = chain[g-1];
			end
			ptt_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.din    (cin),
				.dout   (chain[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tpa_q       <= TpaReset;
			cnt_q       <= '0;
			used_q      <= '0;
			active_q    <= '0;
			page_q      <= '0;
			tile_q      <= '0;
			found_q     <= 1'b0;
			st_q        <= ST_OK;
			hit_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == TpaAddr) begin
				tpa_q <= pwdata[16:0];
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if (match) begin
						found_q <= 1'b1;
						hit_q   <= head_in;
						if (op_t'(req_q.op) == OP_MARK &&
							head.fingerprint != req_q.fingerprint) begin
							st_q <= ST_STALE;
						end else begin
							st_q <= ST_OK;
						end
						if (op_t'(req_q.op) == OP_RETIRE) begin
							active_q <= active_q - 6'd1;
						end
					end else if (alloc_here) begin
						found_q  <= 1'b1;
						hit_q    <= new_e;
						st_q     <= ST_OK;
						used_q   <= used_q + CW'(1);
						active_q <= active_q + 6'd1;
						if (tile_inc >= tpa_q) begin
							tile_q <= '0;
							page_q <= page_q + 5'd1;
						end else begin
							tile_q <= tile_inc;
						end
					end
					if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid && !req_stall) begin
			req_q <= req;
		end
		if (state_q == S_DONE) begin
			rsp_q.active_total <= active_q;
			if (found_q && st_q == ST_OK) begin
				rsp_q.status                <= ST_OK;
				rsp_q.atlas_number          <= hit_q.page;
				rsp_q.tile_number           <= hit_q.tile;
				rsp_q.entry_revision_out    <= hit_q.revision;
				rsp_q.entry_fingerprint_out <= hit_q.fingerprint;
				rsp_q.baked_fingerprint_out <= hit_q.baked;
				rsp_q.is_ready              <= hit_q.ready;
			end else begin
				if (found_q) begin
					rsp_q.status <= st_q;
				end else if (op_t'(req_q.op) == OP_RESERVE) begin
					rsp_q.status <= ST_FULL;
				end else begin
					rsp_q.status <= ST_MISSING;
				end
				rsp_q.atlas_number          <= '0;
				rsp_q.tile_number           <= '0;
				rsp_q.entry_revision_out    <= '0;
				rsp_q.entry_fingerprint_out <= '0;
				rsp_q.baked_fingerprint_out <= '0;
				rsp_q.is_ready              <= 1'b0;
			end
		end
	end

	`PTT_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != S_IDLE, req_stall)
	`PTT_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= CW'(TABLE_DEPTH))
	`PTT_ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == S_DONE, rsp_valid)

endmodule
